[rtl/hsfc_pkg.sv]
// hsfc_pkg: types and constants for the half/single float converter
// no dependencies
package hsfc_pkg;

    localparam logic MODE_H2S = 1'b0;
    localparam logic MODE_S2H = 1'b1;

    localparam logic [31:0] SGL_QNAN = 32'h7fc0_0000;
    localparam logic [31:0] SGL_INF  = 32'h7f80_0000;
    localparam logic [15:0] HLF_QNAN = 16'h7e00;
    localparam logic [15:0] HLF_INF  = 16'h7c00;
    localparam logic [7:0]  EXP_REBIAS = 8'h70;
    localparam logic [7:0]  EXP_SUB_BASE = 8'h67;
    localparam logic [7:0]  EXP_OVF = 8'h8f;
    localparam logic [7:0]  EXP_NORM_MIN = 8'h71;
    localparam logic [7:0]  EXP_SHIFT_BASE = 8'h7e;

    typedef struct packed {
        logic        mode;
        logic [31:0] operand;
    } hsfc_in_t;

    typedef struct packed {
        logic [31:0] result;
        logic        precision_lost;
    } hsfc_out_t;

endpackage

[rtl/hsfc_if.sv]
// hsfc_if: valid/ready channel carrying one word of payload
// depends on nothing; payload type given as a parameter
interface hsfc_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/half_single_float_convert_top.sv]
// throughput: one word per cycle while out_ch.ready is high, set by the input and result registers
// rst_n asynchronous active low clears both valid flags; payload is not reset
// hsfc top: input register, conversion logic, result register
// depends on hsfc_pkg, hsfc_if, hsfc_core
module half_single_float_convert_top
    import hsfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hsfc_if.sink   in_ch,
    hsfc_if.source out_ch
);

    hsfc_in_t  in_reg;
    logic      in_vld_reg;
    hsfc_out_t res_reg;
    logic      res_vld_reg;
    hsfc_out_t conv;
    logic      adv;

    assign adv = !res_vld_reg || out_ch.ready;
    assign in_ch.ready = !in_vld_reg || adv;
    assign out_ch.valid = res_vld_reg;
    assign out_ch.data = res_reg;

    hsfc_core u_core (.in_word(in_reg), .out_word(conv));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                res_vld_reg <= in_vld_reg;
            end
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg)
        begin
            res_reg <= conv;
        end
        if (in_ch.ready && in_ch.valid)
        begin
            in_reg <= in_ch.data;
        end
    end

endmodule

[rtl/hsfc_core.sv]
// hsfc_core: combinational conversion of one word in either direction
// depends on hsfc_pkg
module hsfc_core
    import hsfc_pkg::*;
(
    input  hsfc_in_t  in_word,
    output hsfc_out_t out_word
);

    logic [31:0] h2s;
    logic [15:0] s2h;
    logic        lost;

    always_comb
    begin
        logic        hs;
        logic [4:0]  he;
        logic [9:0]  hf;
        logic [3:0]  lead;
        logic [22:0] nf;
        logic        ss;
        logic [7:0]  se;
        logic [22:0] sf;
        logic [4:0]  sh;
        logic [23:0] mant;
        logic [23:0] mask;
        logic [7:0]  ediff;

        hs = in_word.operand[15];
        he = in_word.operand[14:10];
        hf = in_word.operand[9:0];
        lead = 4'd0;
        for (int i = 1; i <= 9; i++)
        begin
            if (hf[i])
            begin
                lead = 4'(i);
            end
        end
        nf = 23'({hf, 13'd0} << (5'd10 - {1'b0, lead}));
        if (he == 5'h1f)
        begin
            h2s = {hs, 31'd0} | ((hf != 10'd0) ? SGL_QNAN : SGL_INF);
        end
        else if (he != 5'd0)
        begin
            h2s = {hs, 8'({3'd0, he} + EXP_REBIAS), hf, 13'd0};
        end
        else if (hf == 10'd0)
        begin
            h2s = {hs, 31'd0};
        end
        else
        begin
            h2s = {hs, 8'(EXP_SUB_BASE + {4'd0, lead}), nf};
        end

        ss = in_word.operand[31];
        se = in_word.operand[30:23];
        sf = in_word.operand[22:0];
        ediff = EXP_SHIFT_BASE - se;
        sh = ediff[4:0];
        mant = {1'b1, sf} >> sh;
        mask = (24'd1 << sh) - 24'd1;
        lost = 1'b0;
        if (se == 8'hff)
        begin
            s2h = {ss, 15'd0} | ((sf != 23'd0) ? HLF_QNAN : HLF_INF);
        end
        else if (se >= EXP_OVF)
        begin
            lost = 1'b1;
            s2h = {ss, 15'd0} | HLF_INF;
        end
        else if (se >= EXP_NORM_MIN)
        begin
            lost = (sf[12:0] != 13'd0);
            s2h = {ss, 5'(se - EXP_REBIAS), sf[22:13]};
        end
        else if (se >= EXP_SUB_BASE)
        begin
            lost = (({1'b0, sf} & mask) != 24'd0);
            s2h = {ss, mant[14:0]};
        end
        else
        begin
            lost = (se != 8'd0) || (sf != 23'd0);
            s2h = {ss, 15'd0};
        end
    end

    always_comb
    begin
        if (in_word.mode == MODE_S2H)
        begin
            out_word.result = {16'd0, s2h};
            out_word.precision_lost = lost;
        end
        else
        begin
            out_word.result = h2s;
            out_word.precision_lost = 1'b0;
        end
    end

endmodule

[rtl/hsfc_checker.sv]
// hsfc_checker: port-level checks for the converter
// depends on hsfc_pkg; bound to half_single_float_convert_top
module hsfc_checker
    import hsfc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input hsfc_out_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word dropped or changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready |=> out_valid)
        else $error("accepted word did not reach output");

    a_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result[31:16] != 16'd0 |-> !out_data.precision_lost)
        else $error("loss flag on single result");

endmodule

bind half_single_float_convert_top hsfc_checker u_hsfc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

[tb/sv/half_single_float_convert_top_test.sv]
// half_single_float_convert_top_test: directed table then random operands for the
// half/single converter, each result checked against a local conversion predictor
// depends on hsfc_pkg, hsfc_if and half_single_float_convert_top
module half_single_float_convert_top_test;
    import hsfc_pkg::*;

    typedef struct {
        logic        mode;
        logic [31:0] operand;
        logic        known;
        logic [31:0] result;
        logic        lost;
    } vec_t;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_cycles;
    int   mismatches;
    int   cycle_count;
    hsfc_out_t pending_q[$];
    vec_t      vec_table[$];

    hsfc_if #(.payload_t(hsfc_in_t))  in_ch();
    hsfc_if #(.payload_t(hsfc_out_t)) out_ch();

    half_single_float_convert_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic hsfc_out_t convert(input logic mode, input logic [31:0] op);
        hsfc_out_t   r;
        logic [31:0] sgn;
        logic [9:0]  hfrac;
        logic [4:0]  hexp;
        logic [22:0] frac;
        logic [7:0]  ex;
        logic [31:0] mant;
        int          b;
        int          sh;
        r.precision_lost = 1'b0;
        if (mode == MODE_H2S)
        begin
            sgn   = {op[15], 31'b0};
            hfrac = op[9:0];
            hexp  = op[14:10];
            if (hexp == 5'h1f)
                r.result = sgn | ((hfrac != 0) ? SGL_QNAN : SGL_INF);
            else if (hexp != 0)
                r.result = sgn | ({24'b0, {3'b0, hexp} + EXP_REBIAS} << 23)
                           | ({22'b0, hfrac} << 13);
            else if (hfrac == 0)
                r.result = sgn;
            else
            begin
                b = 0;
                for (int k = 9; k > 0; k--)
                    if (hfrac[k] && b == 0)
                        b = k;
                r.result = sgn | ((32'(EXP_SUB_BASE) + 32'(b)) << 23)
                           | (({22'b0, hfrac} << (23 - b)) & 32'h7fffff);
            end
        end
        else
        begin
            sgn  = {16'b0, op[31], 15'b0};
            frac = op[22:0];
            ex   = op[30:23];
            if (ex == 8'hff)
                r.result = sgn | {16'b0, (frac != 0) ? HLF_QNAN : HLF_INF};
            else if (ex >= EXP_OVF)
            begin
                r.result = sgn | {16'b0, HLF_INF};
                r.precision_lost = 1'b1;
            end
            else if (ex >= EXP_NORM_MIN)
            begin
                r.precision_lost = (frac[12:0] != 0);
                r.result = sgn | (32'(ex - EXP_REBIAS) << 10) | 32'(frac >> 13);
            end
            else if (ex >= EXP_SUB_BASE)
            begin
                sh   = 32'(EXP_SHIFT_BASE - ex);
                mant = {9'b0, 1'b1, frac};
                r.precision_lost = ((32'(frac) & ((32'd1 << sh) - 1)) != 0);
                r.result = sgn | (mant >> sh);
            end
            else
            begin
                r.precision_lost = (ex != 0 || frac != 0);
                r.result = sgn;
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic m, input logic [31:0] op, input logic k,
                           input logic [31:0] res, input logic l);
        vec_t v;
        v.mode = m;
        v.operand = op;
        v.known = k;
        v.result = res;
        v.lost = l;
        vec_table.push_back(v);
    endtask

    task automatic send_word(input logic m, input logic [31:0] op);
        hsfc_in_t w;
        w.mode = m;
        w.operand = op;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_q.push_back(convert(m, op));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_single();
        logic [31:0] v;
        logic [7:0]  ex;
        v = $urandom;
        case ($urandom_range(7))
            0: ex = 8'hff;
            1: ex = 8'h00;
            2, 3: ex = 8'(EXP_SUB_BASE) + 8'($urandom_range(10));
            4: ex = 8'(EXP_OVF) + 8'($urandom_range(2)) - 8'd1;
            default: ex = 8'($urandom_range(8'h60, 8'h95));
        endcase
        if ($urandom_range(3) == 0)
            v[12:0] = 13'b0;
        v[30:23] = ex;
        return v;
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= !(snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct);
    end

    always @(posedge clk)
    begin
        hsfc_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h/%b", out_ch.data.result,
                             out_ch.data.precision_lost);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.result !== out_ch.data.result
                    || want.precision_lost !== out_ch.data.precision_lost)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b got %h/%b", want.result,
                                 want.precision_lost, out_ch.data.result,
                                 out_ch.data.precision_lost);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        hsfc_out_t   exp_word;
        logic [31:0] op;
        int          n;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        cycle_count = 0;

        add_row(MODE_H2S, 32'h0000_0000, 1, 32'h0000_0000, 0);
        add_row(MODE_H2S, 32'hffff_8000, 1, 32'h8000_0000, 0);
        add_row(MODE_H2S, 32'h0000_7c00, 1, SGL_INF, 0);
        add_row(MODE_H2S, 32'h0000_fc00, 1, 32'hff80_0000, 0);
        add_row(MODE_H2S, 32'h0000_7e01, 1, SGL_QNAN, 0);
        add_row(MODE_H2S, 32'hffff_ffff, 1, 32'hffc0_0000, 0);
        add_row(MODE_H2S, 32'h0000_0001, 0, 0, 0);
        add_row(MODE_H2S, 32'h0000_03ff, 0, 0, 0);
        add_row(MODE_H2S, 32'h0000_3c00, 1, 32'h3f80_0000, 0);
        add_row(MODE_H2S, 32'h0000_7bff, 0, 0, 0);
        add_row(MODE_S2H, 32'h0000_0000, 1, 32'h0, 0);
        add_row(MODE_S2H, 32'h8000_0000, 1, 32'h8000, 0);
        add_row(MODE_S2H, 32'h7f80_0000, 1, 32'h7c00, 0);
        add_row(MODE_S2H, 32'hff80_0000, 1, 32'hfc00, 0);
        add_row(MODE_S2H, 32'hffff_ffff, 1, 32'hfe00, 0);
        add_row(MODE_S2H, 32'h7f7f_ffff, 1, 32'h7c00, 1);
        add_row(MODE_S2H, 32'h4780_0000, 1, 32'h7c00, 1);
        add_row(MODE_S2H, 32'h3f80_0000, 1, 32'h3c00, 0);
        add_row(MODE_S2H, 32'h3f80_0001, 1, 32'h3c00, 1);
        add_row(MODE_S2H, 32'h3880_0000, 0, 0, 0);
        add_row(MODE_S2H, 32'h3800_0000, 0, 0, 0);
        add_row(MODE_S2H, 32'h3380_0000, 0, 0, 0);
        add_row(MODE_S2H, 32'h337f_ffff, 1, 32'h0, 1);
        add_row(MODE_S2H, 32'h8000_0001, 1, 32'h8000, 1);
        add_row(MODE_S2H, 32'h0040_0000, 1, 32'h0, 1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (vec_table[r])
        begin
            if (vec_table[r].known)
            begin
                exp_word = convert(vec_table[r].mode, vec_table[r].operand);
                if (exp_word.result !== vec_table[r].result
                    || exp_word.precision_lost !== vec_table[r].lost)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: expected %h/%b got %h/%b", r,
                                 vec_table[r].result, vec_table[r].lost,
                                 exp_word.result, exp_word.precision_lost);
                end
            end
            send_word(vec_table[r].mode, vec_table[r].operand);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 68 : 0;
            snk_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 24 : 0;
            for (n = 0; n < 600; n++)
            begin
                if (n == 300 && phase == 2)
                    hold_cycles = 60;
                if ($urandom_range(1))
                    send_word(MODE_S2H, rand_single());
                else
                begin
                    op = $urandom;
                    if ($urandom_range(3) == 0)
                        op[14:10] = ($urandom_range(1)) ? 5'h1f : 5'h00;
                    send_word(MODE_H2S, op);
                end
            end
            in_ch.valid <= 1'b0;
            while (pending_q.size() > 0)
                @(posedge clk);
            @(negedge clk);
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
